### rtl/gb3_pkg.sv
// shared types and constants for the 3x3 gaussian blur
`default_nettype none

package gb3_pkg;

  localparam int PIX_W        = 8;
  localparam int COL_W        = 10;
  localparam int ROW_W        = 12;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_ADDR_W   = 2;
  localparam int CFG_DATA_W   = 13;
  localparam int OUT_TDATA_W  = 32;
  localparam int LINE_DEPTH   = 1024;

  localparam logic [WIDTH_REG_W-1:0]  MAX_WIDTH    = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] MAX_HEIGHT   = 13'd4096;
  localparam logic [WIDTH_REG_W-1:0]  RESET_WIDTH  = 11'd64;
  localparam logic [HEIGHT_REG_W-1:0] RESET_HEIGHT = 13'd64;

  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [ROW_W-1:0] row_t;

  // one line buffer word: pixel two lines up and one line up
  typedef struct packed {
    pix_t top;
    pix_t mid;
  } col_pair_t;

  // left column (x-2) and centre column (x-1) of the neighborhood
  typedef struct packed {
    pix_t l_top;
    pix_t l_mid;
    pix_t l_bot;
    pix_t c_top;
    pix_t c_mid;
    pix_t c_bot;
  } win_t;

  // one result, pixel in the lowest bits
  typedef struct packed {
    logic eof;
    row_t y;
    col_t x;
    pix_t pix;
  } res_t;

endpackage

`default_nettype wire

### rtl/gb3_line_buf.sv
// two line buffers in one memory word, registered read with write bypass
`default_nettype none

module gb3_line_buf import gb3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      rd_en,
  input  col_t      rd_addr,
  output col_pair_t rd_data,
  input  logic      wr_en,
  input  col_t      wr_addr,
  input  col_pair_t wr_data
);

  col_pair_t mem [LINE_DEPTH];
  col_pair_t rd_q;
  col_pair_t byp_data;
  logic      byp;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      byp_data <= wr_data;
    end
  end

  // same address written in the read cycle: take the new word
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (rd_en) begin
      byp <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

`default_nettype wire

### rtl/gb3_kernel.sv
// 1-2-1 weighted 3x3 sum, divided by 16 and rounded down
`default_nettype none

module gb3_kernel import gb3_pkg::*; (
  input  win_t win,
  input  pix_t r_top,
  input  pix_t r_mid,
  input  pix_t r_bot,
  output pix_t filt
);

  localparam int SUM_W = PIX_W + 4;

  logic [SUM_W-1:0] corners;
  logic [SUM_W-1:0] edges;
  logic [SUM_W-1:0] sum;

  always_comb begin
    corners = SUM_W'(win.l_top) + SUM_W'(win.l_bot) + SUM_W'(r_top) + SUM_W'(r_bot);
    edges   = SUM_W'(win.l_mid) + SUM_W'(win.c_top) + SUM_W'(win.c_bot) + SUM_W'(r_mid);
    sum     = corners + (edges << 1) + (SUM_W'(win.c_mid) << 2);
    filt    = sum[SUM_W-1:4];
  end

endmodule

`default_nettype wire

### rtl/gaussian_blur_3x3.sv
// top level of the streaming 3x3 gaussian blur
// pipeline: a pixel's results are registered in the result stage as the pixel leaves the input stage
// throughput: one pixel per cycle while each pixel yields at most one result; a pixel at the
//   end of a line or on the last line yields up to three, sent one per cycle, so it stalls
//   the input until its last result is taken, and so does an output that is held off
// reset: clears position, window and pipeline, sets width and height to 64; line buffer words are not cleared
`default_nettype none

module gaussian_blur_3x3 import gb3_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  // configuration writes
  input  logic                   cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // pixel input
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [PIX_W-1:0]       s_tdata,   // pixel
  // result output
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // out_pixel, out_x, out_y, zero pad
  output logic                   m_tlast,   // last_of_run
  output logic [0:0]             m_tuser    // end_of_frame
);

  // line buffer words are not cleared and never reach a result before they are written

  // frame size, kept as effective values (zero -> 1, above max -> max)
  logic [WIDTH_REG_W-1:0]  width_eff;
  logic [HEIGHT_REG_W-1:0] height_eff;
  logic [WIDTH_REG_W-1:0]  width_next;
  logic [HEIGHT_REG_W-1:0] height_next;
  logic                    wr_width;
  logic                    wr_height;
  logic                    cfg_hit;

  // position of the next input pixel
  col_t col_count;
  row_t row_count;
  logic x_last;
  logic y_last;

  // input stage
  logic s1_valid;
  pix_t s1_px;
  col_t s1_x;
  row_t s1_y;
  logic s1_xl;
  logic s1_yl;
  logic s1_move;
  logic accept;

  // line buffers and window
  col_pair_t lb_rd;
  col_pair_t lb_wr;
  win_t      win;
  pix_t      filt;

  // result stage: up to three results, sent lowest slot first
  res_t       slot [3];
  logic [1:0] s2_cnt;
  logic [1:0] s2_idx;
  logic       s2_free;
  res_t       res_c;
  res_t       res_e;
  res_t       res_b;
  logic       has_c;
  logic       has_e;
  logic       has_b;
  logic       interior;
  logic [1:0] n_res;
  res_t       cur;

  // ---------------------------------------------------------------- configuration
  always_comb begin
    wr_width  = cfg_wr_en && (cfg_addr == REG_IMAGE_WIDTH);
    wr_height = cfg_wr_en && (cfg_addr == REG_IMAGE_HEIGHT);
    cfg_hit   = wr_width || wr_height;

    width_next = cfg_data[WIDTH_REG_W-1:0];
    if (width_next == '0) begin
      width_next = WIDTH_REG_W'(1);
    end else if (width_next > MAX_WIDTH) begin
      width_next = MAX_WIDTH;
    end

    height_next = cfg_data[HEIGHT_REG_W-1:0];
    if (height_next == '0) begin
      height_next = HEIGHT_REG_W'(1);
    end else if (height_next > MAX_HEIGHT) begin
      height_next = MAX_HEIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= RESET_WIDTH;
      height_eff <= RESET_HEIGHT;
    end else begin
      if (wr_width) begin
        width_eff <= width_next;
      end
      if (wr_height) begin
        height_eff <= height_next;
      end
    end
  end

  // ---------------------------------------------------------------- raster position
  assign x_last = ({1'b0, col_count} + WIDTH_REG_W'(1)) == width_eff;
  assign y_last = ({1'b0, row_count} + HEIGHT_REG_W'(1)) == height_eff;

  // a write to the width or height register restarts the frame
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (x_last) begin
        col_count <= '0;
        row_count <= y_last ? '0 : row_count + ROW_W'(1);
      end else begin
        col_count <= col_count + COL_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------- input stage
  assign s1_move  = s1_valid && s2_free;
  assign s_tready = !s1_valid || s1_move;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_px <= s_tdata;
      s1_x  <= col_count;
      s1_y  <= row_count;
      s1_xl <= x_last;
      s1_yl <= y_last;
    end
  end

  // line buffer read at the transfer, written back as the pixel leaves the input stage
  assign lb_wr.top = lb_rd.mid;
  assign lb_wr.mid = s1_px;

  gb3_line_buf u_line_buf (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (col_count),
    .rd_data (lb_rd),
    .wr_en   (s1_move),
    .wr_addr (s1_x),
    .wr_data (lb_wr)
  );

  // window shifts one column per pixel
  always_ff @(posedge clk) begin
    if (rst || cfg_hit) begin
      win <= '0;
    end else if (s1_move) begin
      win.l_top <= win.c_top;
      win.l_mid <= win.c_mid;
      win.l_bot <= win.c_bot;
      win.c_top <= lb_rd.top;
      win.c_mid <= lb_rd.mid;
      win.c_bot <= s1_px;
    end
  end

  gb3_kernel u_kernel (
    .win   (win),
    .r_top (lb_rd.top),
    .r_mid (lb_rd.mid),
    .r_bot (s1_px),
    .filt  (filt)
  );

  // ---------------------------------------------------------------- result build
  always_comb begin
    // centre (x-1, y-1), the right border pixel of the line above, and the bottom line
    has_c    = (s1_y != '0) && (s1_x != '0);
    has_e    = (s1_y != '0) && s1_xl;
    has_b    = s1_yl;
    interior = (s1_x[COL_W-1:1] != '0) && (s1_y[ROW_W-1:1] != '0);

    res_c.pix = interior ? filt : win.c_mid;
    res_c.x   = s1_x - COL_W'(1);
    res_c.y   = s1_y - ROW_W'(1);
    res_c.eof = 1'b0;

    res_e.pix = lb_rd.mid;
    res_e.x   = s1_x;
    res_e.y   = s1_y - ROW_W'(1);
    res_e.eof = 1'b0;

    res_b.pix = s1_px;
    res_b.x   = s1_x;
    res_b.y   = s1_y;
    res_b.eof = s1_xl;

    n_res = {1'b0, has_c} + {1'b0, has_e} + {1'b0, has_b};
  end

  // ---------------------------------------------------------------- result stage
  assign m_tvalid = s2_cnt != '0;
  assign m_tlast  = s2_idx == (s2_cnt - 2'd1);
  assign s2_free  = !m_tvalid || (m_tready && m_tlast);
  assign cur      = slot[s2_idx];
  assign m_tdata  = OUT_TDATA_W'({cur.y, cur.x, cur.pix});
  assign m_tuser  = cur.eof;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_cnt <= '0;
      s2_idx <= '0;
    end else if (s1_move) begin
      s2_cnt <= n_res;
      s2_idx <= '0;
    end else if (m_tvalid && m_tready) begin
      if (m_tlast) begin
        s2_cnt <= '0;
        s2_idx <= '0;
      end else begin
        s2_idx <= s2_idx + 2'd1;
      end
    end
  end

  // compact the present results into the lowest slots
  always_ff @(posedge clk) begin
    if (s1_move) begin
      slot[0] <= has_c ? res_c : (has_e ? res_e : res_b);
      slot[1] <= has_c ? (has_e ? res_e : res_b) : res_b;
      slot[2] <= res_b;
    end
  end

  // ---------------------------------------------------------------- checks
  a_slot_index : assert property (@(posedge clk) disable iff (rst)
    (s2_idx < s2_cnt) || ((s2_idx == '0) && (s2_cnt == '0)))
    else $error("result slot index out of range");

  a_eof_is_last : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> m_tlast)
    else $error("end of frame result not last of its run");

  a_run_continues : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
    else $error("run of results broken off");

  a_pos_in_frame : assert property (@(posedge clk) disable iff (rst)
    ({1'b0, col_count} < width_eff) && ({1'b0, row_count} < height_eff))
    else $error("raster position outside frame");

endmodule

`default_nettype wire

### test/testbench.sv
// self-checking bench for the 3x3 gaussian blur: directed table, random frames, a wide line
`default_nettype none

module testbench;
  import gb3_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // cycles allowed after the last result so pixels that yield nothing leave the pipeline
  localparam int SETTLE = 8;
  localparam int RANDOM_ITEMS = 90;
  localparam int FINAL_ITEMS = 16;

  // register slots that the block does not decode
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic eof;
    logic last;
    row_t y;
    col_t x;
    pix_t pix;
  } blur_res_t;

  typedef enum logic {STIM_CFG, STIM_PIX} stim_kind_t;

  typedef struct {
    stim_kind_t              kind;
    logic [CFG_ADDR_W-1:0]   idx;
    logic [CFG_DATA_W-1:0]   val;    // register value or pixel
    bit                      known;  // result typed in the row
    blur_res_t               want;
  } stim_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_ADDR_W-1:0]  cfg_addr = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [PIX_W-1:0]       s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;   // out_pixel, out_x, out_y, zero pad
  logic                   m_tlast;   // last_of_run
  logic [0:0]             m_tuser;   // end_of_frame

  gaussian_blur_3x3 i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  always #5 clk = ~clk;

  // shadow copy of the block: registers, line buffers, window, position
  logic [WIDTH_REG_W-1:0]  sh_width;
  logic [HEIGHT_REG_W-1:0] sh_height;
  pix_t                    sh_prev  [LINE_DEPTH];
  pix_t                    sh_prev2 [LINE_DEPTH];
  win_t                    sh_win;
  int unsigned             sh_col;
  int unsigned             sh_row;

  // results still to come out of the block, oldest first
  blur_res_t outgoing_pixels[$];
  stim_row_t directed_rows[$];

  int errors = 0;
  bit idle_en = 1'b1;
  int stall_left = 0;

  // zero is taken as one, oversize values saturate
  function automatic int unsigned frame_w();
    if (sh_width == 0) return 1;
    if (sh_width > MAX_WIDTH) return MAX_WIDTH;
    return sh_width;
  endfunction

  function automatic int unsigned frame_h();
    if (sh_height == 0) return 1;
    if (sh_height > MAX_HEIGHT) return MAX_HEIGHT;
    return sh_height;
  endfunction

  // one pixel through the shadow filter: up to three results, then advance the state
  task automatic blur_pixel(input pix_t px, output int n, output blur_res_t r[3]);
    int unsigned w, h, x, y, cx, cy, sum;
    pix_t top, mid, v;
    w = frame_w();
    h = frame_h();
    x = sh_col;
    y = sh_row;
    if (x >= w) x = 0;
    if (y >= h) y = 0;
    top = sh_prev2[x];
    mid = sh_prev[x];
    n = 0;
    // centre of the window, one column left and one line up
    if (y >= 1 && x >= 1) begin
      cx = x - 1;
      cy = y - 1;
      if (cx >= 1 && cx + 2 <= w && cy >= 1 && cy + 2 <= h) begin
        sum = sh_win.l_top + 2 * sh_win.c_top + top
            + 2 * sh_win.l_mid + 4 * sh_win.c_mid + 2 * mid
            + sh_win.l_bot + 2 * sh_win.c_bot + px;
        v = pix_t'(sum >> 4);
      end else begin
        v = sh_win.c_mid;
      end
      r[n] = '{pix: v, x: col_t'(cx), y: row_t'(cy), last: 1'b0, eof: 1'b0};
      n++;
    end
    // right border of the line above
    if (y >= 1 && x + 1 == w) begin
      r[n] = '{pix: mid, x: col_t'(w - 1), y: row_t'(y - 1), last: 1'b0, eof: 1'b0};
      n++;
    end
    // bottom line passes straight through
    if (y + 1 == h) begin
      r[n] = '{pix: px, x: col_t'(x), y: row_t'(y), last: 1'b0, eof: (x + 1 == w)};
      n++;
    end
    if (n > 0) r[n-1].last = 1'b1;
    sh_win.l_top = sh_win.c_top;
    sh_win.l_mid = sh_win.c_mid;
    sh_win.l_bot = sh_win.c_bot;
    sh_win.c_top = top;
    sh_win.c_mid = mid;
    sh_win.c_bot = px;
    sh_prev2[x] = mid;
    sh_prev[x] = px;
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) y = 0;
    end
    sh_col = x;
    sh_row = y;
  endtask

  function automatic pix_t rand_pixel();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
    return pix_t'($urandom_range(0, 255));
  endfunction

  function automatic void add_cfg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    directed_rows.push_back('{kind: STIM_CFG, idx: idx, val: val, known: 1'b0, want: '0});
  endfunction

  function automatic void add_pix(pix_t px);
    directed_rows.push_back('{kind: STIM_PIX, idx: '0, val: px, known: 1'b0, want: '0});
  endfunction

  // pixel whose single result can be read off directly
  function automatic void add_known(pix_t px, pix_t rpix, col_t rx, row_t ry, logic reof);
    directed_rows.push_back('{kind: STIM_PIX, idx: '0, val: px, known: 1'b1,
                              want: '{pix: rpix, x: rx, y: ry, last: 1'b1, eof: reof}});
  endfunction

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  // one pixel transfer, optionally after a gap; results pushed at acceptance
  task automatic send_pixel(input pix_t px, input bit known, input blur_res_t want);
    int n, gap;
    blur_res_t r[3];
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= px;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    blur_pixel(px, n, r);
    if (known) begin
      outgoing_pixels.push_back(want);
    end else begin
      for (int k = 0; k < n; k++) outgoing_pixels.push_back(r[k]);
    end
  endtask

  // stop sending and wait until every result is out and the pipeline is empty
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (outgoing_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    // a decoded write restarts the frame, line buffers keep their contents
    if (idx == REG_IMAGE_WIDTH || idx == REG_IMAGE_HEIGHT) begin
      if (idx == REG_IMAGE_WIDTH) sh_width = val[WIDTH_REG_W-1:0];
      else sh_height = val;
      sh_col = 0;
      sh_row = 0;
      sh_win = '0;
    end
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // receiver: ready drops in random bursts while idling is enabled
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // every result transfer is checked against the oldest pending result
  always @(posedge clk) begin : check_out
    blur_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.pix  = m_tdata[7:0];
      got.x    = m_tdata[17:8];
      got.y    = m_tdata[29:18];
      got.last = m_tlast;
      got.eof  = m_tuser[0];
      if (outgoing_pixels.size() == 0) begin
        note_error($sformatf("unexpected result: pix %0d x %0d y %0d last %0b eof %0b",
                             got.pix, got.x, got.y, got.last, got.eof));
      end else begin
        want = outgoing_pixels.pop_front();
        if (got !== want || m_tdata[31:30] !== 2'b00) begin
          note_error($sformatf(
            "mismatch: want pix %0d x %0d y %0d last %0b eof %0b, got pix %0d x %0d y %0d last %0b eof %0b pad %0b",
            want.pix, want.x, want.y, want.last, want.eof,
            got.pix, got.x, got.y, got.last, got.eof, m_tdata[31:30]));
        end
      end
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int sent, count;
    sh_width  = RESET_WIDTH;
    sh_height = RESET_HEIGHT;
    sh_win    = '0;
    sh_col    = 0;
    sh_row    = 0;
    for (int i = 0; i < LINE_DEPTH; i++) begin
      sh_prev[i]  = '0;
      sh_prev2[i] = '0;
    end

    // reset frame is 64x64, nothing comes out on its first line
    add_pix(8'hA5);
    add_pix(8'h5A);
    // 1x1 frame: each pixel is its own whole frame
    add_cfg(REG_IMAGE_WIDTH, 13'd1);
    add_cfg(REG_IMAGE_HEIGHT, 13'd1);
    add_known(8'h00, 8'h00, 10'd0, 12'd0, 1'b1);
    add_known(8'hFF, 8'hFF, 10'd0, 12'd0, 1'b1);
    // 3x3 checkerboard with an undecoded write in the middle of the frame
    add_cfg(REG_IMAGE_WIDTH, 13'd3);
    add_cfg(REG_IMAGE_HEIGHT, 13'd3);
    for (int i = 0; i < 9; i++) begin
      add_pix((i % 2) ? 8'h00 : 8'hFF);
      if (i == 3) add_cfg(REG_SPARE_B, 13'h1FFF);
    end
    // full-scale frame, largest weighted sum
    for (int i = 0; i < 9; i++) add_pix(8'hFF);
    // single line: pure pass-through
    add_cfg(REG_IMAGE_HEIGHT, 13'd1);
    add_known(8'h10, 8'h10, 10'd0, 12'd0, 1'b0);
    add_known(8'h20, 8'h20, 10'd1, 12'd0, 1'b0);
    add_known(8'h40, 8'h40, 10'd2, 12'd0, 1'b1);
    // zero width behaves as one column
    add_cfg(REG_IMAGE_WIDTH, 13'd0);
    add_cfg(REG_SPARE_A, 13'h0AAA);
    add_known(8'h33, 8'h33, 10'd0, 12'd0, 1'b1);
    // all-ones writes saturate to the largest frame
    add_cfg(REG_IMAGE_WIDTH, 13'h07FF);
    add_cfg(REG_IMAGE_HEIGHT, 13'h1FFF);
    add_pix(8'hC3);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == STIM_CFG) begin
        drain();
        write_reg(directed_rows[k].idx, directed_rows[k].val);
      end else begin
        send_pixel(pix_t'(directed_rows[k].val), directed_rows[k].known, directed_rows[k].want);
      end
    end

    // random frames, mostly complete, some cut short by a new setting or run on into the next
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 3) != 0);
      drain();
      case ((sent == 0) ? 2 : $urandom_range(0, 3))
        0: write_reg(REG_IMAGE_WIDTH, 13'($urandom_range(1, 8)));
        1: write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(1, 6)));
        default: begin
          write_reg(REG_IMAGE_WIDTH,
                    13'(($urandom_range(0, 4) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8)));
          write_reg(REG_IMAGE_HEIGHT, 13'($urandom_range(1, 6)));
        end
      endcase
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 13'($urandom));
      count = frame_w() * frame_h();
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      else if ($urandom_range(0, 2) == 0) count += $urandom_range(1, frame_w());
      for (int k = 0; k < count && sent < RANDOM_ITEMS; k++) begin
        // hold off once mid-stream until the output has caught up
        if (sent == RANDOM_ITEMS / 2) drain();
        send_pixel(rand_pixel(), 1'b0, '0);
        sent++;
      end
    end

    // start of the widest line, no idling from here on
    idle_en = 1'b0;
    drain();
    write_reg(REG_IMAGE_WIDTH, 13'(MAX_WIDTH));
    write_reg(REG_IMAGE_HEIGHT, 13'd1);
    for (int k = 0; k < FINAL_ITEMS; k++) send_pixel(rand_pixel(), 1'b0, '0);

    drain();
    repeat (20) @(posedge clk);
    if (outgoing_pixels.size() != 0)
      note_error($sformatf("%0d results never arrived", outgoing_pixels.size()));
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
